// File: hw/rtl/button_counter_seven_segment_scan_defines.svh
// assertion helpers for the button counter block
`ifndef BUTTON_COUNTER_SEVEN_SEGMENT_SCAN_DEFINES_SVH
`define BUTTON_COUNTER_SEVEN_SEGMENT_SCAN_DEFINES_SVH

// generic clocked assertion with asynchronous active-low reset
`define BCCS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// same, on the block's own clock and reset
`define BCCS_ASSERT_CLK(label, prop) \
  `BCCS_ASSERT(label, clk_i, rst_ni, prop)

`endif

// File: hw/rtl/bccs_pkg.sv
`default_nettype none

package bccs_pkg;

  localparam logic [7:0]  LOCKOUT_RESET = 8'd100;
  localparam logic [15:0] COUNT_RESET   = 16'd1;

  // four decimal digits, index 0 is thousands, index 3 is units
  typedef logic [3:0][3:0] bccs_digits_t;

  localparam bccs_digits_t DIGITS_RESET = {4'd1, 4'd0, 4'd0, 4'd0};
  // 65535 modulo 10000
  localparam bccs_digits_t DIGITS_WRAP_DOWN = {4'd5, 4'd3, 4'd5, 4'd5};
  localparam bccs_digits_t DIGITS_ZERO = {4'd0, 4'd0, 4'd0, 4'd0};

  typedef struct packed {
    logic clear;
    logic step;
    logic down;
    logic wrap;
  } bccs_step_t;

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bccs_bcd.sv
`default_nettype none

module bccs_bcd import bccs_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire bccs_step_t   cmd_i,
  output bccs_digits_t      digits_o
);

  bccs_digits_t digits_q, digits_d;
  bccs_digits_t base, inc, dec;

  always_comb begin
    logic carry;
    logic borrow;
    base   = cmd_i.clear ? DIGITS_ZERO : digits_q;
    inc    = base;
    dec    = base;
    carry  = 1'b1;
    borrow = 1'b1;
    for (int i = 3; i >= 0; i--) begin
      if (carry) begin
        if (base[i] == 4'd9) begin
          inc[i] = 4'd0;
        end else begin
          inc[i] = base[i] + 4'd1;
          carry  = 1'b0;
        end
      end
      if (borrow) begin
        if (base[i] == 4'd0) begin
          dec[i] = 4'd9;
        end else begin
          dec[i] = base[i] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
  end

  always_comb begin
    digits_d = base;
    if (cmd_i.step) begin
      if (cmd_i.wrap) begin
        digits_d = cmd_i.down ? DIGITS_WRAP_DOWN : DIGITS_ZERO;
      end else begin
        digits_d = cmd_i.down ? dec : inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= DIGITS_RESET;
    end else if (en_i) begin
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

endmodule

`default_nettype wire

// File: hw/rtl/button_counter_seven_segment_scan.sv
// path: an accepted request passes the input register, then the result register
// throughput: one request per cycle while the output is not stalled; the input register takes one more request
//   while a finished result is held by a stalled output
// reset: count 1, counting up, stopped, no lockout, scan at digit 0, lockout reload 100
`default_nettype none

module button_counter_seven_segment_scan import bccs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [7:0]  cfg_lockout_ticks_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        clear_button_n_i,
  input  wire logic        direction_button_n_i,
  input  wire logic        run_button_n_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [3:0]  digit_enable_o,
  output      logic [6:0]  segments_o,
  output      logic [15:0] count_value_o
);

  logic        s1_valid_q;
  logic        s1_clr_n_q, s1_dir_n_q, s1_run_n_q;
  logic        out_valid_q;
  logic [3:0]  digit_enable_q, digit_enable_d;
  logic [6:0]  segments_q, segments_d;
  logic [7:0]  lockout_ticks_q;
  logic [7:0]  lockout_q, lockout_d;
  logic [15:0] count_q, count_d, base;
  logic        down_q, down_d;
  logic        running_q, running_d;
  logic [1:0]  scan_q;
  logic        s1_move, s1_load;
  logic        idle, clr_act, dir_act, run_act;
  bccs_step_t  cmd;
  bccs_digits_t digits;

  assign cfg_ready_o = 1'b1;

  assign s1_move    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_move;
  assign s1_load    = in_valid_i & ~in_stall_o;

  // button handling, lockout and counting
  always_comb begin
    idle    = (lockout_q == 8'd0);
    clr_act = idle & ~s1_clr_n_q;
    dir_act = idle & s1_clr_n_q & ~s1_dir_n_q;
    run_act = idle & s1_clr_n_q & s1_dir_n_q & ~s1_run_n_q;

    down_d    = down_q ^ dir_act;
    running_d = running_q ^ run_act;
    base      = clr_act ? 16'd0 : count_q;

    cmd.clear = clr_act;
    cmd.step  = idle & running_d;
    cmd.down  = down_d;
    cmd.wrap  = down_d ? (base == 16'd0) : (base == 16'hFFFF);

    if (cmd.step) begin
      count_d = down_d ? base - 16'd1 : base + 16'd1;
    end else begin
      count_d = base;
    end

    if (!idle) begin
      lockout_d = lockout_q - 8'd1;
    end else if (clr_act | dir_act | run_act) begin
      lockout_d = lockout_ticks_q;
    end else begin
      lockout_d = lockout_q;
    end

    digit_enable_d = 4'b0001 << scan_q;
    segments_d     = seg_of(digits[scan_q]);
  end

  bccs_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_move),
    .cmd_i    (cmd),
    .digits_o (digits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_ticks_q <= LOCKOUT_RESET;
    end else if (cfg_valid_i) begin
      lockout_ticks_q <= cfg_lockout_ticks_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= COUNT_RESET;
      down_q      <= 1'b0;
      running_q   <= 1'b0;
      lockout_q   <= 8'd0;
      scan_q      <= 2'd0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        down_q      <= down_d;
        running_q   <= running_d;
        lockout_q   <= lockout_d;
        scan_q      <= scan_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload and result payload
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_clr_n_q <= clear_button_n_i;
      s1_dir_n_q <= direction_button_n_i;
      s1_run_n_q <= run_button_n_i;
    end
    if (s1_move) begin
      digit_enable_q <= digit_enable_d;
      segments_q     <= segments_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_enable_o = digit_enable_q;
  assign segments_o     = segments_q;
  assign count_value_o  = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/bccs_checker.sv
`default_nettype none

`include "button_counter_seven_segment_scan_defines.svh"

module bccs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  digit_enable_o,
  input wire logic [6:0]  segments_o,
  input wire logic [15:0] count_value_o
);

  // one digit lit per result
  `BCCS_ASSERT_CLK(a_enable_onehot, out_valid_o |-> $onehot(digit_enable_o))

  // a lit digit always shows some segment
  `BCCS_ASSERT_CLK(a_segments_lit, out_valid_o |-> (segments_o != 7'd0))

  // scan moves one digit on between consecutive results
  `BCCS_ASSERT_CLK(a_scan_rotates,
    (out_valid_o && !out_stall_i) ##1 out_valid_o |->
      (digit_enable_o == (($past(digit_enable_o) << 1) | ($past(digit_enable_o) >> 3))))

  // held result does not change
  `BCCS_ASSERT_CLK(a_out_hold,
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(digit_enable_o) && $stable(segments_o)
       && $stable(count_value_o)))

endmodule

bind button_counter_seven_segment_scan bccs_checker u_bccs_checker (.*);

`default_nettype wire
